// ----- src/llcm_pkg.sv -----
// ----------------------------------------------------------------------------
// llcm_pkg
// Shared types and codes for the latched pattern bank mapper.
// ----------------------------------------------------------------------------
package llcm_pkg;

  // Bus operation codes
  localparam logic [1:0] OP_CPU_READ  = 2'd0;
  localparam logic [1:0] OP_CPU_WRITE = 2'd1;
  localparam logic [1:0] OP_PAT_READ  = 2'd2;

  // Target memory codes
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_PROM = 2'd1;
  localparam logic [1:0] TGT_WRAM = 2'd2;
  localparam logic [1:0] TGT_CROM = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W     = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 8'd1;
  localparam int unsigned CFG_DATA_W    = 9;

  localparam int unsigned PRG_COUNT_W = 5;
  localparam int unsigned CHR_COUNT_W = 9;
  localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RST = 5'd8;
  localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RST = 9'd16;

  // Remainder unit operand widths
  localparam int unsigned DIVIDEND_W = 8;
  localparam int unsigned DIVISOR_W  = 9;

  // Latch trigger patterns within a 4 KB half
  localparam logic [11:0] TRIG_MASK = 12'hFF8;
  localparam logic [11:0] TRIG_FD   = 12'hFD8;
  localparam logic [11:0] TRIG_FE   = 12'hFE8;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_WRAM_RD,
    KIND_WRAM_WR,
    KIND_PRG_SWITCH,
    KIND_PRG_FIXED,
    KIND_CHR
  } kind_e;

  // One classified request between front and back
  typedef struct packed {
    kind_e       kind;
    logic [13:0] off;
    logic [7:0]  data;    // store byte or raw bank number
    logic        mirror;  // mirroring after this request
  } entry_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] rem;
  } mod_rsp_t;

endpackage

// ----- src/llcm_front.sv -----
// ----------------------------------------------------------------------------
// llcm_front
// Accepts bus requests, applies register writes and latch updates in order,
// and pushes one classified entry per request.
// ----------------------------------------------------------------------------
module llcm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      operation_i,
  input  logic [15:0]     address_i,
  input  logic [7:0]      write_data_i,
  input  logic            full_i,
  output logic            push_o,
  output llcm_pkg::entry_t entry_o
);
  import llcm_pkg::*;

  logic [3:0] prg_sel_q, prg_sel_d;
  logic [7:0] low_fd_q, low_fd_d, low_fe_q, low_fe_d;
  logic [7:0] high_fd_q, high_fd_d, high_fe_q, high_fe_d;
  logic       latch_low_q, latch_low_d, latch_high_q, latch_high_d;
  logic       mirror_q, mirror_d;
  logic       accept;
  logic [11:0] pat_off;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;
  assign pat_off    = address_i[11:0];

  always_comb begin
    prg_sel_d    = prg_sel_q;
    low_fd_d     = low_fd_q;
    low_fe_d     = low_fe_q;
    high_fd_d    = high_fd_q;
    high_fe_d    = high_fe_q;
    latch_low_d  = latch_low_q;
    latch_high_d = latch_high_q;
    mirror_d     = mirror_q;
    entry_o.kind = KIND_NONE;
    entry_o.off  = address_i[13:0];
    entry_o.data = write_data_i;
    case (operation_i)
      OP_CPU_READ: begin
        if (address_i[15:13] == 3'b011) begin
          entry_o.kind = KIND_WRAM_RD;
        end else if (address_i[15:14] == 2'b10) begin
          entry_o.kind = KIND_PRG_SWITCH;
          entry_o.data = {4'b0, prg_sel_q};
        end else if (address_i[15:14] == 2'b11) begin
          entry_o.kind = KIND_PRG_FIXED;
        end
      end
      OP_CPU_WRITE: begin
        if (address_i[15:13] == 3'b011) begin
          entry_o.kind = KIND_WRAM_WR;
        end else begin
          case (address_i[15:12])
            4'hA: prg_sel_d = write_data_i[3:0];
            4'hB: low_fd_d  = write_data_i;
            4'hC: low_fe_d  = write_data_i;
            4'hD: high_fd_d = write_data_i;
            4'hE: high_fe_d = write_data_i;
            4'hF: mirror_d  = write_data_i[0];
            default: ;
          endcase
        end
      end
      OP_PAT_READ: begin
        entry_o.kind = KIND_CHR;
        if (address_i[12]) begin
          entry_o.data = latch_high_q ? high_fe_q : high_fd_q;
          if ((pat_off & TRIG_MASK) == TRIG_FD) latch_high_d = 1'b0;
          else if ((pat_off & TRIG_MASK) == TRIG_FE) latch_high_d = 1'b1;
        end else begin
          entry_o.data = latch_low_q ? low_fe_q : low_fd_q;
          if ((pat_off & TRIG_MASK) == TRIG_FD) latch_low_d = 1'b0;
          else if ((pat_off & TRIG_MASK) == TRIG_FE) latch_low_d = 1'b1;
        end
      end
      default: ;
    endcase
    entry_o.mirror = mirror_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_sel_q    <= '0;
      low_fd_q     <= '0;
      low_fe_q     <= '0;
      high_fd_q    <= '0;
      high_fe_q    <= '0;
      latch_low_q  <= 1'b1;
      latch_high_q <= 1'b1;
      mirror_q     <= 1'b0;
    end else if (accept) begin
      prg_sel_q    <= prg_sel_d;
      low_fd_q     <= low_fd_d;
      low_fe_q     <= low_fe_d;
      high_fd_q    <= high_fd_d;
      high_fe_q    <= high_fe_d;
      latch_low_q  <= latch_low_d;
      latch_high_q <= latch_high_d;
      mirror_q     <= mirror_d;
    end
  end

endmodule

// ----- src/llcm_queue.sv -----
// ----------------------------------------------------------------------------
// llcm_queue
// Small synchronous FIFO between the front and the back.
// ----------------------------------------------------------------------------
module llcm_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

// ----- src/llcm_mod.sv -----
// ----------------------------------------------------------------------------
// llcm_mod
// Serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module llcm_mod (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  llcm_pkg::mod_req_t req_i,
  output llcm_pkg::mod_rsp_t rsp_o
);
  import llcm_pkg::*;

  localparam int unsigned CntW = $clog2(DIVIDEND_W);

  logic                  busy_q, done_q;
  logic [CntW-1:0]       cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] dvd_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    trial, diff;

  // Shift in the next dividend bit, subtract when it fits
  assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = (trial >= {1'b0, dvs_q}) ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[DIVIDEND_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DIVIDEND_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[DIVIDEND_W-2:0], 1'b0};
    end
  end

endmodule

// ----- src/llcm_back.sv -----
// ----------------------------------------------------------------------------
// llcm_back
// Pops classified entries, reduces bank numbers through the remainder unit
// and drives the registered result channel.
// ----------------------------------------------------------------------------
module llcm_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [llcm_pkg::PRG_COUNT_W-1:0]      prg_count_i,
  input  logic [llcm_pkg::CHR_COUNT_W-1:0]      chr_count_i,
  input  llcm_pkg::entry_t                      head_i,
  input  logic                                  empty_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [1:0]                            target_o,
  output logic [19:0]                           phys_address_o,
  output logic                                  ram_write_o,
  output logic [7:0]                            store_data_o,
  output logic                                  mirror_horizontal_o
);
  import llcm_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic     state_q, state_d;
  entry_t   hold_q, src;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;
  logic     out_free, load_out;
  logic [PRG_COUNT_W-1:0] fixed_bank;
  logic [1:0]  tgt_d;
  logic [19:0] phys_d;
  logic        wr_d;
  logic [7:0]  store_d;
  logic        valid_q;
  logic [1:0]  tgt_q;
  logic [19:0] phys_q;
  logic        wr_q;
  logic [7:0]  store_q;
  logic        mirror_q;

  llcm_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign out_free   = !valid_q || out_ready_i;
  assign fixed_bank = (prg_count_i == '0) ? '0 : prg_count_i - 1'b1;

  always_comb begin
    state_d          = state_q;
    pop_o            = 1'b0;
    load_out         = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = head_i.data;
    mod_req.divisor  = (head_i.kind == KIND_CHR)
                     ? ((chr_count_i == '0) ? DIVISOR_W'(1) : chr_count_i)
                     : ((prg_count_i == '0) ? DIVISOR_W'(1)
                                            : DIVISOR_W'(prg_count_i));
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          if (head_i.kind == KIND_PRG_SWITCH || head_i.kind == KIND_CHR) begin
            mod_req.start = 1'b1;
            state_d       = ST_DIV;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      ST_DIV: begin
        // Output is empty here: the request started only when it was free
        if (mod_rsp.done) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    src     = (state_q == ST_DIV) ? hold_q : head_i;
    tgt_d   = TGT_NONE;
    phys_d  = '0;
    wr_d    = 1'b0;
    store_d = '0;
    case (src.kind)
      KIND_WRAM_RD: begin
        tgt_d  = TGT_WRAM;
        phys_d = {7'b0, src.off[12:0]};
      end
      KIND_WRAM_WR: begin
        tgt_d   = TGT_WRAM;
        phys_d  = {7'b0, src.off[12:0]};
        wr_d    = 1'b1;
        store_d = src.data;
      end
      KIND_PRG_SWITCH: begin
        tgt_d  = TGT_PROM;
        phys_d = {2'b0, mod_rsp.rem[3:0], src.off};
      end
      KIND_PRG_FIXED: begin
        tgt_d  = TGT_PROM;
        phys_d = {1'b0, fixed_bank, src.off};
      end
      KIND_CHR: begin
        tgt_d  = TGT_CROM;
        phys_d = {mod_rsp.rem, src.off[11:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) hold_q <= head_i;
    if (load_out) begin
      tgt_q    <= tgt_d;
      phys_q   <= phys_d;
      wr_q     <= wr_d;
      store_q  <= store_d;
      mirror_q <= src.mirror;
    end
  end

  assign out_valid_o         = valid_q;
  assign target_o            = tgt_q;
  assign phys_address_o      = phys_q;
  assign ram_write_o         = wr_q;
  assign store_data_o        = store_q;
  assign mirror_horizontal_o = mirror_q;

endmodule

// ----- src/latched_chr_bank_mapper.sv -----
// ----------------------------------------------------------------------------
// latched_chr_bank_mapper
// Cartridge bank mapper with latch-switched pattern banks.
// ----------------------------------------------------------------------------
// Each request on the input channel yields exactly one result. The front
// takes one request per cycle while the queue has room; it applies register
// writes and latch flips in request order, so every queued entry already
// carries its raw bank number and the mirroring after that request. Work RAM
// accesses, fixed-bank program reads and ignored or register writes are
// loaded into the result register at their pop. Switchable program reads
// and pattern reads reduce the bank number modulo the configured count in a
// serial remainder unit that retires one dividend bit per cycle, and the
// back pops no further entry until the remainder is in the result register.
// So plain accesses leave the back one per cycle while the result register
// is free, and banked reads hold the back until their remainder is done.
// Configuration writes are always taken; write them only while idle.
// ----------------------------------------------------------------------------
module latched_chr_bank_mapper #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [llcm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [llcm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Request channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       operation_i,
  input  logic [15:0]                      address_i,
  input  logic [7:0]                       write_data_i,
  // Result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       target_o,
  output logic [19:0]                      phys_address_o,
  output logic                             ram_write_o,
  output logic [7:0]                       store_data_o,
  output logic                             mirror_horizontal_o
);
  import llcm_pkg::*;

  logic [PRG_COUNT_W-1:0] prg_count_q;
  logic [CHR_COUNT_W-1:0] chr_count_q;
  entry_t                 push_entry, head_entry;
  logic                   push, pop, q_full, q_empty;
  logic [$bits(entry_t)-1:0] head_bits;

  // Config registers: hold until written, unknown indexes drop
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= PRG_COUNT_RST;
      chr_count_q <= CHR_COUNT_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PRG_COUNT) prg_count_q <= cfg_data_i[PRG_COUNT_W-1:0];
      else if (cfg_index_i == CFG_CHR_COUNT) chr_count_q <= cfg_data_i;
    end
  end

  // Front: accept, classify, advance mapper state
  llcm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .full_i       (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Queue: decouple front and back stalls
  llcm_queue #(
    .Width ($bits(entry_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (head_bits),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign head_entry = entry_t'(head_bits);

  // Back: compute the physical offset and hold the result
  llcm_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .prg_count_i         (prg_count_q),
    .chr_count_i         (chr_count_q),
    .head_i              (head_entry),
    .empty_i             (q_empty),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .target_o            (target_o),
    .phys_address_o      (phys_address_o),
    .ram_write_o         (ram_write_o),
    .store_data_o        (store_data_o),
    .mirror_horizontal_o (mirror_horizontal_o)
  );

endmodule
